>>> rtl/core/rotation_matrix_to_quaternion_unit_macros.svh
// Assertion macros shared by the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define RMQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define RMQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define RMQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/rmq_pkg.sv
// Shared types and helpers for the rotation matrix to quaternion pipeline.
package rmq_pkg;

  // Which quaternion component comes straight from the square root.
  typedef enum logic [1:0] {
    ROOT_W,
    ROOT_X,
    ROOT_Y,
    ROOT_Z
  } root_sel_t;

  // Flow status that each pipeline cell reports to its neighbors.
  typedef struct packed {
    logic in_ready;
    logic out_valid;
  } cell_stat_t;

  // A stage can load when it is empty or its content moves on.
  function automatic logic stage_open(input logic valid, input logic next_ready);
    return !valid || next_ready;
  endfunction

endpackage

>>> rtl/core/rmq_sqrt_cell.sv
// One restoring square root step: retires two radicand bits, yields one root bit.
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     out_ready,
  output cell_stat_t               stat,
  input  logic [2*FRAC_BITS+3:0]   rad_in,
  input  logic [FRAC_BITS+3:0]     rem_in,
  input  logic [FRAC_BITS+1:0]     root_in,
  input  logic [SIDE_W-1:0]        side_in,
  output logic [2*FRAC_BITS+3:0]   rad,
  output logic [FRAC_BITS+3:0]     rem,
  output logic [FRAC_BITS+1:0]     root,
  output logic [SIDE_W-1:0]        side
);

  localparam int RW = 2 * FRAC_BITS + 4;

  logic                 valid;
  logic [FRAC_BITS+5:0] cur;
  logic [FRAC_BITS+5:0] trial;
  logic [FRAC_BITS+5:0] diff;
  logic                 ge;

  assign stat.in_ready  = stage_open(valid, out_ready);
  assign stat.out_valid = valid;

  assign cur   = {rem_in, rad_in[RW-1 -: 2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign ge    = cur >= trial;
  assign diff  = cur - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (stat.in_ready) begin
      valid <= in_valid;
    end
    if (stat.in_ready && in_valid) begin
      rem  <= ge ? diff[FRAC_BITS+3:0] : cur[FRAC_BITS+3:0];
      root <= {root_in[FRAC_BITS:0], ge};
      rad  <= {rad_in[RW-3:0], 2'b00};
      side <= side_in;
    end
  end

endmodule

>>> rtl/core/rmq_div_cell.sv
// One restoring division step for three lanes sharing one divisor.
module rmq_div_cell import rmq_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   out_ready,
  output cell_stat_t             stat,
  input  logic [FRAC_BITS+2:0]   dv_in,
  input  logic [FRAC_BITS+2:0]   rem_in [3],
  input  logic [FRAC_BITS+2:0]   nlo_in [3],
  input  logic [FRAC_BITS+2:0]   quo_in [3],
  input  logic [SIDE_W-1:0]      side_in,
  output logic [FRAC_BITS+2:0]   dv,
  output logic [FRAC_BITS+2:0]   rem [3],
  output logic [FRAC_BITS+2:0]   nlo [3],
  output logic [FRAC_BITS+2:0]   quo [3],
  output logic [SIDE_W-1:0]      side
);

  localparam int NW = FRAC_BITS + 3;

  logic          valid;
  logic [NW:0]   cur  [3];
  logic [NW:0]   diff [3];
  logic          ge   [3];

  assign stat.in_ready  = stage_open(valid, out_ready);
  assign stat.out_valid = valid;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cur[l]  = {rem_in[l], nlo_in[l][NW-1]};
      ge[l]   = cur[l] >= {1'b0, dv_in};
      diff[l] = cur[l] - {1'b0, dv_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (stat.in_ready) begin
      valid <= in_valid;
    end
    if (stat.in_ready && in_valid) begin
      dv   <= dv_in;
      side <= side_in;
      for (int l = 0; l < 3; l++) begin
        rem[l] <= ge[l] ? diff[l][NW-1:0] : cur[l][NW-1:0];
        nlo[l] <= {nlo_in[l][NW-2:0], 1'b0};
        quo[l] <= {quo_in[l][NW-2:0], ge[l]};
      end
    end
  end

endmodule

>>> rtl/core/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion converter, top level.
// Input channel: in_valid / in_stall carry the nine Q2.F matrix entries
// m11..m33; an item transfers on a rising edge with in_valid high and in_stall
// low. Output channel: out_valid / out_stall carry qw, qx, qy, qz in Q2.F,
// saturated to the field range.
// From input transfer to out_valid an item passes one front stage (trace, axis
// pick, radicand, numerators), FRAC_BITS + 2 square root cells of one root bit
// each, one divisor setup stage, FRAC_BITS + 3 division cells of one quotient
// bit each for three lanes in parallel, and one output register.
// Throughput is one item per cycle while out_stall is low; every cell is a full stage.
// When out_stall is high the output register holds; empty cells upstream keep
// filling, so in_stall rises only once every cell is occupied.
// Reset (rst, synchronous) empties the pipeline; in-flight items are dropped.
`include "rotation_matrix_to_quaternion_unit_macros.svh"
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FRAC_BITS+1:0] m11,
  input  logic signed [FRAC_BITS+1:0] m12,
  input  logic signed [FRAC_BITS+1:0] m13,
  input  logic signed [FRAC_BITS+1:0] m21,
  input  logic signed [FRAC_BITS+1:0] m22,
  input  logic signed [FRAC_BITS+1:0] m23,
  input  logic signed [FRAC_BITS+1:0] m31,
  input  logic signed [FRAC_BITS+1:0] m32,
  input  logic signed [FRAC_BITS+1:0] m33,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FRAC_BITS+1:0] qw,
  output logic signed [FRAC_BITS+1:0] qx,
  output logic signed [FRAC_BITS+1:0] qy,
  output logic signed [FRAC_BITS+1:0] qz
);

  localparam int W   = FRAC_BITS + 2;
  localparam int XW  = W + 3;
  localparam int RW  = 2 * FRAC_BITS + 4;
  localparam int NW  = FRAC_BITS + 3;
  localparam int SQ  = FRAC_BITS + 2;
  localparam int DQ  = FRAC_BITS + 3;
  // sqrt side: {sel, neg[2:0], mag2, mag1, mag0}
  localparam int S1W = 2 + 3 + 3 * NW;
  // div side: {sel, neg[2:0], ovf[2:0], zero, rootq}
  localparam int S2W = 2 + 3 + 3 + 1 + W;

  localparam logic signed [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS+1:0] ONE_R = (FRAC_BITS+2)'(ONE_X);
  localparam logic [W-1:0]  SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  SAT_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [NW-1:0] POS_LIM = NW'(SAT_MAX);
  localparam logic [NW-1:0] NEG_LIM = {2'b01, {(NW-2){1'b0}}};

  // ---------------- front stage ----------------
  logic signed [XW-1:0] tr;
  logic                 tpos;
  logic                 pick_y;
  logic                 pick_z;
  logic signed [W-1:0]  mii_y;
  logic signed [W-1:0]  mii;
  logic signed [XW-1:0] rb;
  logic [RW-1:0]        rad0;
  logic signed [W:0]    d_a, d_b, d_c, s_12, s_13, s_23;
  logic signed [W:0]    lane [3];
  logic [NW-1:0]        mag  [3];
  logic [2:0]           neg;
  root_sel_t            sel0;

  assign tr     = XW'(m11) + XW'(m22) + XW'(m33);
  assign tpos   = tr > 0;
  assign pick_y = m22 > m11;
  assign mii_y  = pick_y ? m22 : m11;
  assign pick_z = m33 > mii_y;
  assign mii    = pick_z ? m33 : mii_y;
  assign rb     = tpos ? tr + ONE_X : ONE_X + (XW'(mii) <<< 1) - tr;
  // Clip a negative radicand to zero.
  assign rad0   = rb[XW-1] ? '0 : {1'b0, rb[W:0], {FRAC_BITS{1'b0}}};

  assign d_a  = (W+1)'(m32) - (W+1)'(m23);
  assign d_b  = (W+1)'(m13) - (W+1)'(m31);
  assign d_c  = (W+1)'(m21) - (W+1)'(m12);
  assign s_12 = (W+1)'(m12) + (W+1)'(m21);
  assign s_13 = (W+1)'(m13) + (W+1)'(m31);
  assign s_23 = (W+1)'(m23) + (W+1)'(m32);

  always_comb begin
    if (tpos) begin
      sel0 = ROOT_W;
    end else if (pick_z) begin
      sel0 = ROOT_Z;
    end else if (pick_y) begin
      sel0 = ROOT_Y;
    end else begin
      sel0 = ROOT_X;
    end
    // Lanes carry the three non-root components in w, x, y, z order.
    unique case (sel0)
      ROOT_W: begin
        lane[0] = d_a; lane[1] = d_b; lane[2] = d_c;
      end
      ROOT_X: begin
        lane[0] = d_a; lane[1] = s_12; lane[2] = s_13;
      end
      ROOT_Y: begin
        lane[0] = d_b; lane[1] = s_12; lane[2] = s_23;
      end
      default: begin
        lane[0] = d_c; lane[1] = s_13; lane[2] = s_23;
      end
    endcase
    for (int l = 0; l < 3; l++) begin
      neg[l] = lane[l][W];
      mag[l] = neg[l] ? NW'(-lane[l]) : NW'(lane[l]);
    end
  end

  // ---------------- square root chain ----------------
  logic                 sq_v    [SQ+1];
  logic [RW-1:0]        sq_rad  [SQ+1];
  logic [FRAC_BITS+3:0] sq_rem  [SQ+1];
  logic [FRAC_BITS+1:0] sq_root [SQ+1];
  logic [S1W-1:0]       sq_side [SQ+1];
  cell_stat_t           sq_st   [1:SQ];
  logic                 s0_open;
  logic                 p_open;

  assign s0_open    = stage_open(sq_v[0], sq_st[1].in_ready);
  assign in_stall   = !s0_open;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (s0_open) begin
      sq_v[0] <= in_valid;
    end
    if (s0_open && in_valid) begin
      sq_rad[0]  <= rad0;
      sq_side[0] <= {sel0, neg, mag[2], mag[1], mag[0]};
    end
  end

  for (genvar c = 1; c <= SQ; c++) begin : g_sqrt
    logic nxt_ready;
    if (c < SQ) begin : g_mid
      assign nxt_ready = sq_st[c+1].in_ready;
    end else begin : g_last
      assign nxt_ready = p_open;
    end
    rmq_sqrt_cell #(.FRAC_BITS(FRAC_BITS), .SIDE_W(S1W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_v[c-1]),
      .out_ready(nxt_ready),
      .stat     (sq_st[c]),
      .rad_in   (sq_rad[c-1]),
      .rem_in   (sq_rem[c-1]),
      .root_in  (sq_root[c-1]),
      .side_in  (sq_side[c-1]),
      .rad      (sq_rad[c]),
      .rem      (sq_rem[c]),
      .root     (sq_root[c]),
      .side     (sq_side[c])
    );
    assign sq_v[c] = sq_st[c].out_valid;
  end

  // ---------------- divisor setup stage ----------------
  logic [FRAC_BITS+1:0] r_fin;
  logic [NW-1:0]        dv_set;
  logic [NW-1:0]        mag_s [3];
  logic [NW-1:0]        hi_s  [3];
  logic [2:0]           ovf_s;
  logic [W-1:0]         rootq_s;
  logic [W:0]           r_inc;
  root_sel_t            sel_s;

  assign r_fin   = sq_root[SQ];
  assign dv_set  = {r_fin, 1'b0};
  assign r_inc   = {1'b0, r_fin} + 1'b1;
  assign rootq_s = r_inc[W:1];
  assign sel_s   = root_sel_t'(sq_side[SQ][S1W-1 -: 2]);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_s[l] = sq_side[SQ][l*NW +: NW];
      hi_s[l]  = {3'b000, mag_s[l][NW-1:3]};
      ovf_s[l] = hi_s[l] >= dv_set;
    end
  end

  logic           dv_v    [DQ+1];
  logic [NW-1:0]  dv_dv   [DQ+1];
  logic [NW-1:0]  dv_rem  [DQ+1][3];
  logic [NW-1:0]  dv_nlo  [DQ+1][3];
  logic [NW-1:0]  dv_quo  [DQ+1][3];
  logic [S2W-1:0] dv_side [DQ+1];
  cell_stat_t     dv_st   [1:DQ];

  assign p_open = stage_open(dv_v[0], dv_st[1].in_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (p_open) begin
      dv_v[0] <= sq_v[SQ];
    end
    if (p_open && sq_v[SQ]) begin
      dv_dv[0]   <= dv_set;
      dv_side[0] <= {sq_side[SQ][S1W-1 -: 5], ovf_s, r_fin == '0, rootq_s};
      for (int l = 0; l < 3; l++) begin
        // An overflowing lane saturates; start it from zero.
        dv_rem[0][l] <= ovf_s[l] ? '0 : hi_s[l];
        dv_nlo[0][l] <= {mag_s[l][2:0], {FRAC_BITS{1'b0}}};
        dv_quo[0][l] <= '0;
      end
    end
  end

  // ---------------- division chain ----------------
  logic out_open;

  for (genvar c = 1; c <= DQ; c++) begin : g_div
    logic nxt_ready;
    if (c < DQ) begin : g_mid
      assign nxt_ready = dv_st[c+1].in_ready;
    end else begin : g_last
      assign nxt_ready = out_open;
    end
    rmq_div_cell #(.FRAC_BITS(FRAC_BITS), .SIDE_W(S2W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv_v[c-1]),
      .out_ready(nxt_ready),
      .stat     (dv_st[c]),
      .dv_in    (dv_dv[c-1]),
      .rem_in   (dv_rem[c-1]),
      .nlo_in   (dv_nlo[c-1]),
      .quo_in   (dv_quo[c-1]),
      .side_in  (dv_side[c-1]),
      .dv       (dv_dv[c]),
      .rem      (dv_rem[c]),
      .nlo      (dv_nlo[c]),
      .quo      (dv_quo[c]),
      .side     (dv_side[c])
    );
    assign dv_v[c] = dv_st[c].out_valid;
  end

  // ---------------- output stage ----------------
  root_sel_t     sel_f;
  logic [2:0]    neg_f;
  logic [2:0]    ovf_f;
  logic          zero_f;
  logic [W-1:0]  rootq_f;
  logic [NW-1:0] nq   [3];
  logic [W-1:0]  res  [3];
  logic [W-1:0]  comp [4];

  assign sel_f   = root_sel_t'(dv_side[DQ][S2W-1 -: 2]);
  assign neg_f   = dv_side[DQ][S2W-3 -: 3];
  assign ovf_f   = dv_side[DQ][S2W-6 -: 3];
  assign zero_f  = dv_side[DQ][W];
  assign rootq_f = dv_side[DQ][W-1:0];
  assign out_open = stage_open(out_valid, !out_stall);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nq[l] = NW'(0) - dv_quo[DQ][l];
      if (zero_f) begin
        res[l] = '0;
      end else if (neg_f[l]) begin
        res[l] = (ovf_f[l] || dv_quo[DQ][l] > NEG_LIM) ? SAT_MIN : nq[l][W-1:0];
      end else begin
        res[l] = (ovf_f[l] || dv_quo[DQ][l] > POS_LIM) ? SAT_MAX : dv_quo[DQ][l][W-1:0];
      end
    end
    unique case (sel_f)
      ROOT_W: begin
        comp[0] = rootq_f; comp[1] = res[0]; comp[2] = res[1]; comp[3] = res[2];
      end
      ROOT_X: begin
        comp[0] = res[0]; comp[1] = rootq_f; comp[2] = res[1]; comp[3] = res[2];
      end
      ROOT_Y: begin
        comp[0] = res[0]; comp[1] = res[1]; comp[2] = rootq_f; comp[3] = res[2];
      end
      default: begin
        comp[0] = res[0]; comp[1] = res[1]; comp[2] = res[2]; comp[3] = rootq_f;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= dv_v[DQ];
    end
    if (out_open && dv_v[DQ]) begin
      qw <= comp[0];
      qx <= comp[1];
      qy <= comp[2];
      qz <= comp[3];
    end
  end

  // ---------------- checks ----------------
  `RMQ_ASSERT_IMP(a_trace_root_min, clk, rst, sq_v[SQ] && sel_s == ROOT_W, r_fin >= ONE_R)
  `RMQ_ASSERT_IMP(a_rootq_range, clk, rst, dv_v[0], dv_side[0][W-1] == 1'b0)
  `RMQ_ASSERT_IMP(a_div_rem0, clk, rst, dv_v[DQ] && !ovf_f[0], dv_rem[DQ][0] < dv_dv[DQ])
  `RMQ_ASSERT_IMP(a_div_rem1, clk, rst, dv_v[DQ] && !ovf_f[1], dv_rem[DQ][1] < dv_dv[DQ])
  `RMQ_ASSERT_IMP(a_div_rem2, clk, rst, dv_v[DQ] && !ovf_f[2], dv_rem[DQ][2] < dv_dv[DQ])
  `RMQ_ASSERT_NXT(a_front_moves, clk, rst, sq_v[0] && sq_st[1].in_ready, sq_v[1])

endmodule
